[rtl/bilinear_2x_upscaler_unit_macros.svh]
// assertion macros for the 2x upscaler
`ifndef BILINEAR_2X_UPSCALER_UNIT_MACROS_SVH
`define BILINEAR_2X_UPSCALER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define BU2X_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bu2x assertion failed");
`define BU2X_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bu2x assertion failed");
`else
`define BU2X_ASSERT(label, clk, rst, prop)
`define BU2X_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/bu2x_pkg.sv]
`default_nettype none

package bu2x_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = 16;
   localparam int PIX_W     = 8;
   localparam int FW_W      = 13;
   localparam int FH_W      = 16;

   localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
   localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam int RSP_PAYLOAD_W = COL_W + ROW_W + 4 * PIX_W;
   localparam int RSP_DATA_W    = ((RSP_PAYLOAD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_DATA_W - RSP_PAYLOAD_W;

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = QPTR_W + 1;

   // block kinds, also bit positions in the block mask
   localparam int NBLK   = 4;
   localparam int BLK_W  = $clog2(NBLK);
   localparam logic [BLK_W-1:0] BLK_INNER  = 2'd0;
   localparam logic [BLK_W-1:0] BLK_RIGHT  = 2'd1;
   localparam logic [BLK_W-1:0] BLK_BOTTOM = 2'd2;
   localparam logic [BLK_W-1:0] BLK_CORNER = 2'd3;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] above;
      logic [PIX_W-1:0] lcur;
      logic [PIX_W-1:0] lprev;
      logic [NBLK-1:0]  mask;
      logic             frame_end;
   } q_entry_type;

endpackage

`default_nettype wire

[rtl/bu2x_front.sv]
`default_nettype none

`include "bilinear_2x_upscaler_unit_macros.svh"

module bu2x_front
   import bu2x_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [PIX_W-1:0]      pixel_in,
   output logic                       push,
   output q_entry_type                push_entry,
   input  wire logic                  q_full
);

   logic [FW_W-1:0]  fw_ff;
   logic [FH_W-1:0]  fh_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] wm1;
   logic [ROW_W-1:0] hm1;
   logic             last_col, last_row, accept;

   logic [PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [PIX_W-1:0] above_ff;

   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_px_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [NBLK-1:0]  s1_mask_ff, s1_mask_in;
   logic             s1_fe_ff;
   logic             s1_go;

   logic [PIX_W-1:0] lcur_ff, lprev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FW_RESET;
         fh_ff <= FH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  fw_ff <= csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: fh_ff <= csr_wdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // geometry with zero treated as one and width saturated
   always_comb begin
      if (fw_ff == '0) begin
         wm1 = '0;
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         wm1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         wm1 = COL_W'(fw_ff - 1'b1);
      end
      hm1      = (fh_ff == '0) ? '0 : fh_ff - 1'b1;
      last_col = col_ff >= wm1;
      last_row = row_ff >= hm1;
   end

   assign s1_go      = s1_valid_ff && ((s1_mask_ff == '0) || !q_full);
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_mask_in             = '0;
      s1_mask_in[BLK_INNER]  = (row_ff != '0) && (col_ff != '0);
      s1_mask_in[BLK_RIGHT]  = (row_ff != '0) && last_col;
      s1_mask_in[BLK_BOTTOM] = last_row && (col_ff != '0);
      s1_mask_in[BLK_CORNER] = last_row && last_col;
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         lcur_ff     <= '0;
         lprev_ff    <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_go) begin
            lcur_ff  <= s1_px_ff;
            lprev_ff <= above_ff;
         end
      end
   end

   // line store, read before write at the same address
   always_ff @(posedge clock) begin
      if (accept) begin
         above_ff        <= line_mem[col_ff];
         line_mem[col_ff] <= pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= pixel_in;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_mask_ff <= s1_mask_in;
         s1_fe_ff   <= last_col && last_row;
      end
   end

   assign push = s1_valid_ff && (s1_mask_ff != '0) && !q_full;

   always_comb begin
      push_entry.col       = s1_col_ff;
      push_entry.row       = s1_row_ff;
      push_entry.px        = s1_px_ff;
      push_entry.above     = above_ff;
      push_entry.lcur      = lcur_ff;
      push_entry.lprev     = lprev_ff;
      push_entry.mask      = s1_mask_ff;
      push_entry.frame_end = s1_fe_ff;
   end

   `BU2X_ASSERT_NEXT(a_front_fill, clock, reset, accept, s1_valid_ff)
   `BU2X_ASSERT(a_front_fe_mask, clock, reset, (s1_valid_ff && s1_fe_ff) |-> s1_mask_ff[BLK_CORNER])

endmodule

`default_nettype wire

[rtl/bu2x_queue.sv]
`default_nettype none

`include "bilinear_2x_upscaler_unit_macros.svh"

module bu2x_queue
   import bu2x_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire q_entry_type  push_entry,
   output logic              full,
   output logic              head_valid,
   output q_entry_type       head_entry,
   input  wire logic         pop
);

   q_entry_type       slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_pop;

   assign full       = count_ff == QCNT_W'(QDEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= QPTR_W'((32'(wr_ptr_ff) + 1) % QDEPTH);
         end
         if (do_pop) begin
            rd_ptr_ff <= QPTR_W'((32'(rd_ptr_ff) + 1) % QDEPTH);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `BU2X_ASSERT(a_q_bound, clock, reset, count_ff <= QCNT_W'(QDEPTH))
   `BU2X_ASSERT_NEXT(a_q_grow, clock, reset, (push && !do_pop), (count_ff == $past(count_ff) + 1'b1))

endmodule

`default_nettype wire

[rtl/bu2x_back.sv]
`default_nettype none

`include "bilinear_2x_upscaler_unit_macros.svh"

module bu2x_back
   import bu2x_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire q_entry_type            head_entry,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tuser
);

   logic              bk_valid_ff;
   q_entry_type       bk_entry_ff;
   logic [NBLK-1:0]   bk_mask_ff;
   logic [BLK_W-1:0]  sel;
   logic [NBLK-1:0]   rem;
   logic              out_free, emit, done;

   logic [COL_W-1:0]  b_col;
   logic [ROW_W-1:0]  b_row;
   logic [PIX_W-1:0]  pa, pb, pc, pd;
   logic [PIX_W:0]    sum_ab, sum_ac;
   logic [PIX_W+1:0]  sum_all;

   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic              rsp_last_ff, rsp_user_ff;

   always_comb begin
      if (bk_mask_ff[BLK_INNER]) begin
         sel = BLK_INNER;
      end else if (bk_mask_ff[BLK_RIGHT]) begin
         sel = BLK_RIGHT;
      end else if (bk_mask_ff[BLK_BOTTOM]) begin
         sel = BLK_BOTTOM;
      end else begin
         sel = BLK_CORNER;
      end
      rem      = bk_mask_ff;
      rem[sel] = 1'b0;
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = bk_valid_ff && out_free;
   assign done     = rem == '0;
   assign pop      = head_valid && (!bk_valid_ff || (emit && done));

   always_comb begin
      unique case (sel)
         BLK_INNER: begin
            b_col = bk_entry_ff.col - 1'b1;
            b_row = bk_entry_ff.row - 1'b1;
            pa    = bk_entry_ff.lprev;
            pb    = bk_entry_ff.above;
            pc    = bk_entry_ff.lcur;
            pd    = bk_entry_ff.px;
         end
         BLK_RIGHT: begin
            b_col = bk_entry_ff.col;
            b_row = bk_entry_ff.row - 1'b1;
            pa    = bk_entry_ff.above;
            pb    = bk_entry_ff.above;
            pc    = bk_entry_ff.px;
            pd    = bk_entry_ff.px;
         end
         BLK_BOTTOM: begin
            b_col = bk_entry_ff.col - 1'b1;
            b_row = bk_entry_ff.row;
            pa    = bk_entry_ff.lcur;
            pb    = bk_entry_ff.px;
            pc    = bk_entry_ff.lcur;
            pd    = bk_entry_ff.px;
         end
         default: begin
            b_col = bk_entry_ff.col;
            b_row = bk_entry_ff.row;
            pa    = bk_entry_ff.px;
            pb    = bk_entry_ff.px;
            pc    = bk_entry_ff.px;
            pd    = bk_entry_ff.px;
         end
      endcase
      sum_ab  = {1'b0, pa} + {1'b0, pb};
      sum_ac  = {1'b0, pa} + {1'b0, pc};
      sum_all = {2'b00, pa} + {2'b00, pb} + {2'b00, pc} + {2'b00, pd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bk_valid_ff <= 1'b0;
      end else if (pop) begin
         bk_valid_ff <= 1'b1;
      end else if (emit && done) begin
         bk_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         bk_entry_ff <= head_entry;
         bk_mask_ff  <= head_entry.mask;
      end else if (emit) begin
         bk_mask_ff  <= rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, sum_all[PIX_W+1:2], sum_ac[PIX_W:1],
                         sum_ab[PIX_W:1], pa, b_row, b_col};
         rsp_last_ff <= done;
         rsp_user_ff <= done && bk_entry_ff.frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   `BU2X_ASSERT(a_back_live, clock, reset, bk_valid_ff |-> (bk_mask_ff != '0))
   `BU2X_ASSERT(a_back_fe_last, clock, reset, (rsp_valid_ff && rsp_user_ff) |-> rsp_last_ff)

endmodule

`default_nettype wire

[rtl/bilinear_2x_upscaler_unit.sv]
`default_nettype none

// 2x bilinear upscaler for 8-bit grey pixels in raster order. One pixel is taken per
// clock and one 2x2 output block word leaves per clock while rsp_tready is high; a
// pixel normally yields one block, the last pixel of a row two and, on the last row,
// up to four, so those pixels hold the input back through req_tready once the
// four-word queue between the classifier and the block expander fills. The
// single-port 4096 x 8 line store is read and written once per pixel and sets the
// one-pixel-per-clock pace. Blocks lag one row: block (x, y) leaves when pixel
// (x+1, y+1) arrives, and the last row's own blocks follow straight away. The line
// store needs no clearing pass. Write frame_width and frame_height only while the
// block is idle.
module bilinear_2x_upscaler_unit
   import bu2x_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // pixel_in
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // block_col, block_row, top_left, top_right, bottom_left, bottom_right, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,   // last_of_run
   output logic                       rsp_tuser    // frame_end
);

   logic        push, q_full, head_valid, pop;
   q_entry_type push_entry, head_entry;

   bu2x_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .pixel_in   (req_tdata[PIX_W-1:0]),
      .push       (push),
      .push_entry (push_entry),
      .q_full     (q_full)
   );

   bu2x_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   bu2x_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
